// File: hdl/esl_pkg.sv
// ----------------------------------------------------------------------------
// esl_pkg
// Types, register map and microcode store for the ESC throttle slew limiter.
// ----------------------------------------------------------------------------
package esl_pkg;

  localparam int unsigned PULSE_W    = 12;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned AGE_W      = 16;
  localparam int unsigned MAP_W      = THR_W + 1;
  localparam int unsigned STEP_W     = 2 * THR_W;
  localparam int unsigned PADDR_W    = 5;
  localparam int unsigned PDATA_W    = 32;
  localparam int unsigned PC_W       = 3;

  // Reverse mode remaps throttle into 0.555 .. 1.0 (Q1.16).
  localparam logic [THR_W-1:0] REV_BASE  = 16'd36372;
  localparam logic [THR_W-2:0] REV_SPAN  = 15'd29164;
  localparam logic [THR_W-1:0] REV_ROUND = 16'd32768;

  localparam logic [PULSE_W-1:0] PULSE_MIN_RST  = 12'd1000;
  localparam logic [PULSE_W-1:0] PULSE_MAX_RST  = 12'd2000;
  localparam logic [THR_W-1:0]   SLEW_RST       = 16'd65535;
  localparam logic [AGE_W-1:0]   TIMEOUT_RST    = 16'd500;
  localparam logic [AGE_W-1:0]   HOLD_RST       = 16'd3000;

  typedef enum logic [2:0] {
    REG_PULSE_MIN  = 3'd0,
    REG_PULSE_MAX  = 3'd1,
    REG_SLEW       = 3'd2,
    REG_TIMEOUT    = 3'd3,
    REG_HOLD       = 3'd4,
    REG_REVERSE    = 3'd5,
    REG_PWR_SENSE  = 3'd6,
    REG_UNUSED     = 3'd7
  } reg_idx_t;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_AGE,
    OP_SLEW,
    OP_REMAP,
    OP_PULSE,
    OP_HOLD,
    OP_REQUEST
  } op_t;

  typedef struct packed {
    op_t  op;
    logic jump_on_hold;
    pc_t  jump_pc;
    logic last;
  } uword_t;

  localparam pc_t PC_TICK    = 3'd0;
  localparam pc_t PC_HOLD    = 3'd4;
  localparam pc_t PC_REQUEST = 3'd5;

  // Tick program: age update (branch to hold), slew, remap, pulse.
  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    w = '{op: OP_NOP, jump_on_hold: 1'b0, jump_pc: PC_TICK, last: 1'b1};
    unique case (pc)
      3'd0: w = '{op: OP_AGE,     jump_on_hold: 1'b1, jump_pc: PC_HOLD, last: 1'b0};
      3'd1: w = '{op: OP_SLEW,    jump_on_hold: 1'b0, jump_pc: PC_TICK, last: 1'b0};
      3'd2: w = '{op: OP_REMAP,   jump_on_hold: 1'b0, jump_pc: PC_TICK, last: 1'b0};
      3'd3: w = '{op: OP_PULSE,   jump_on_hold: 1'b0, jump_pc: PC_TICK, last: 1'b1};
      3'd4: w = '{op: OP_HOLD,    jump_on_hold: 1'b0, jump_pc: PC_TICK, last: 1'b1};
      3'd5: w = '{op: OP_REQUEST, jump_on_hold: 1'b0, jump_pc: PC_TICK, last: 1'b1};
      default: w = '{op: OP_NOP,  jump_on_hold: 1'b0, jump_pc: PC_TICK, last: 1'b1};
    endcase
    return w;
  endfunction

endpackage

// File: hdl/esc_throttle_slew_limiter.sv
// ----------------------------------------------------------------------------
// esc_throttle_slew_limiter
// ESC pulse width generator with start-up hold, command timeout and a
// slew-limited throttle, run by a small microcoded sequencer.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  in       sink       in_valid / in_stall    action, elapsed_ms, power_present,
//                                             request_throttle
//  out      source     out_valid / out_stall  pulse_us, in_startup, timed_out
//  cfg      APB slave  psel/penable/pready    paddr, pwrite, pwdata, prdata
//
//  A request runs the request step, a tick in start-up hold the age and hold
//  steps and any other tick the age, slew, remap and pulse steps, one step at
//  a time after the item is accepted; the last step waits while the output stalls.
//  Reset is synchronous; it restores the register defaults, idles the
//  sequencer and empties the output register.
//  The next item is taken while a result still waits; a stalled output only
//  freezes the sequencer on its last step.
// ----------------------------------------------------------------------------
module esc_throttle_slew_limiter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                action,
  input  logic [esl_pkg::AGE_W-1:0]           elapsed_ms,
  input  logic                                power_present,
  input  logic [esl_pkg::THR_W-1:0]           request_throttle,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [esl_pkg::PULSE_W-1:0]         pulse_us,
  output logic                                in_startup,
  output logic                                timed_out,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [esl_pkg::PADDR_W-1:0]         paddr,
  input  logic [esl_pkg::PDATA_W-1:0]         pwdata,
  output logic [esl_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);

  localparam int unsigned PULSE_W = esl_pkg::PULSE_W;
  localparam int unsigned THR_W   = esl_pkg::THR_W;
  localparam int unsigned AGE_W   = esl_pkg::AGE_W;
  localparam int unsigned MAP_W   = esl_pkg::MAP_W;
  localparam int unsigned STEP_W  = esl_pkg::STEP_W;
  localparam int unsigned PDATA_W = esl_pkg::PDATA_W;
  localparam int unsigned PROD_W  = MAP_W + PULSE_W;

  // Configuration registers.
  logic [PULSE_W-1:0] pulse_min;
  logic [PULSE_W-1:0] pulse_max;
  logic [THR_W-1:0]   slew;
  logic [AGE_W-1:0]   timeout;
  logic [AGE_W-1:0]   hold;
  logic               reverse;
  logic               pwr_sense;

  esl_pkg::reg_idx_t  reg_idx;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = esl_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_min <= esl_pkg::PULSE_MIN_RST;
      pulse_max <= esl_pkg::PULSE_MAX_RST;
      slew      <= esl_pkg::SLEW_RST;
      timeout   <= esl_pkg::TIMEOUT_RST;
      hold      <= esl_pkg::HOLD_RST;
      reverse   <= 1'b0;
      pwr_sense <= 1'b0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        esl_pkg::REG_PULSE_MIN: pulse_min <= pwdata[PULSE_W-1:0];
        esl_pkg::REG_PULSE_MAX: pulse_max <= pwdata[PULSE_W-1:0];
        esl_pkg::REG_SLEW:      slew      <= pwdata[THR_W-1:0];
        esl_pkg::REG_TIMEOUT:   timeout   <= pwdata[AGE_W-1:0];
        esl_pkg::REG_HOLD:      hold      <= pwdata[AGE_W-1:0];
        esl_pkg::REG_REVERSE:   reverse   <= pwdata[0];
        esl_pkg::REG_PWR_SENSE: pwr_sense <= pwdata[0];
        esl_pkg::REG_UNUSED:    ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      esl_pkg::REG_PULSE_MIN: prdata = PDATA_W'(pulse_min);
      esl_pkg::REG_PULSE_MAX: prdata = PDATA_W'(pulse_max);
      esl_pkg::REG_SLEW:      prdata = PDATA_W'(slew);
      esl_pkg::REG_TIMEOUT:   prdata = PDATA_W'(timeout);
      esl_pkg::REG_HOLD:      prdata = PDATA_W'(hold);
      esl_pkg::REG_REVERSE:   prdata = PDATA_W'(reverse);
      esl_pkg::REG_PWR_SENSE: prdata = PDATA_W'(pwr_sense);
      esl_pkg::REG_UNUSED:    prdata = '0;
    endcase
  end

  // Sequencer.
  logic               running;
  esl_pkg::pc_t       pc;
  esl_pkg::uword_t    uw;
  logic               exec;
  logic               accept;

  // Latched item.
  logic               action_q;
  logic [AGE_W-1:0]   elapsed_q;
  logic               power_q;
  logic [THR_W-1:0]   request_q;

  // Block state.
  logic [THR_W-1:0]   current_throttle;
  logic [THR_W-1:0]   target_throttle;
  logic [AGE_W-1:0]   power_on_age;
  logic [AGE_W-1:0]   command_age;
  logic [PULSE_W-1:0] last_pulse;
  logic               last_startup;

  // Work registers.
  logic [STEP_W-1:0]  step_q;
  logic [MAP_W-1:0]   map_q;
  logic               to_flag;
  logic               out_timed_out;

  assign uw       = esl_pkg::ucode(pc);
  assign accept   = in_valid && !in_stall;
  assign in_stall = running;
  // The last step writes the result, so it waits for a free output register.
  assign exec     = running && !(uw.last && out_valid && out_stall);

  // Age update datapath.
  logic [AGE_W:0]     poa_sum;
  logic [AGE_W:0]     ca_sum;
  logic [AGE_W-1:0]   poa_next;
  logic [AGE_W-1:0]   ca_next;
  logic               hold_next;
  logic               timeout_next;

  always_comb begin
    poa_sum  = {1'b0, power_on_age} + {1'b0, elapsed_q};
    ca_sum   = {1'b0, command_age} + {1'b0, elapsed_q};
    poa_next = poa_sum[AGE_W] ? {AGE_W{1'b1}} : poa_sum[AGE_W-1:0];
    ca_next  = ca_sum[AGE_W] ? {AGE_W{1'b1}} : ca_sum[AGE_W-1:0];
    if (pwr_sense && !power_q) begin
      poa_next = '0;
    end
    hold_next    = poa_next < hold;
    timeout_next = ca_next > timeout;
  end

  // Slew datapath.
  logic               rising;
  logic [THR_W-1:0]   diff;
  logic [THR_W-1:0]   move;

  always_comb begin
    rising = target_throttle > current_throttle;
    diff   = rising ? target_throttle - current_throttle
                    : current_throttle - target_throttle;
    move   = ({{(STEP_W-THR_W){1'b0}}, diff} > step_q) ? step_q[THR_W-1:0] : diff;
  end

  // Reverse remap datapath.
  logic [STEP_W-1:0]  rev_prod;
  logic [MAP_W-1:0]   rev_map;

  always_comb begin
    rev_prod = STEP_W'(current_throttle) * STEP_W'(esl_pkg::REV_SPAN)
             + STEP_W'(esl_pkg::REV_ROUND);
    rev_map  = MAP_W'(esl_pkg::REV_BASE) + MAP_W'(rev_prod[STEP_W-1:THR_W]);
  end

  // Pulse mapping datapath; a reversed range still lands between the limits.
  logic               range_up;
  logic [PULSE_W-1:0] span;
  logic [PROD_W-1:0]  map_prod;
  logic [PULSE_W-1:0] offset;
  logic [PULSE_W-1:0] pulse_next;

  always_comb begin
    range_up   = pulse_max >= pulse_min;
    span       = range_up ? pulse_max - pulse_min : pulse_min - pulse_max;
    map_prod   = PROD_W'(map_q) * PROD_W'(span);
    offset     = map_prod[THR_W +: PULSE_W];
    pulse_next = range_up ? pulse_min + offset : pulse_min - offset;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      pc      <= esl_pkg::PC_TICK;
    end else if (accept) begin
      running <= 1'b1;
      pc      <= action ? esl_pkg::PC_REQUEST : esl_pkg::PC_TICK;
    end else if (exec) begin
      if (uw.last) begin
        running <= 1'b0;
      end else if (uw.jump_on_hold && hold_next) begin
        pc <= uw.jump_pc;
      end else begin
        pc <= pc + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action_q  <= action;
      elapsed_q <= elapsed_ms;
      power_q   <= power_present;
      request_q <= request_throttle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_throttle <= '0;
      target_throttle  <= '0;
      power_on_age     <= '0;
      command_age      <= '0;
      last_pulse       <= '0;
      last_startup     <= 1'b1;
      to_flag          <= 1'b0;
    end else if (accept) begin
      to_flag <= 1'b0;
    end else if (exec) begin
      unique case (uw.op)
        esl_pkg::OP_AGE: begin
          power_on_age <= poa_next;
          command_age  <= ca_next;
          if (timeout_next) begin
            current_throttle <= '0;
            target_throttle  <= '0;
            to_flag          <= 1'b1;
          end
        end
        esl_pkg::OP_SLEW: begin
          current_throttle <= rising ? current_throttle + move
                                     : current_throttle - move;
        end
        esl_pkg::OP_PULSE: begin
          last_pulse   <= pulse_next;
          last_startup <= 1'b0;
        end
        esl_pkg::OP_HOLD: begin
          last_pulse   <= pulse_min;
          last_startup <= 1'b1;
        end
        esl_pkg::OP_REQUEST: begin
          target_throttle <= request_q;
          command_age     <= '0;
        end
        esl_pkg::OP_REMAP, esl_pkg::OP_NOP: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (exec && uw.op == esl_pkg::OP_AGE) begin
      step_q <= STEP_W'(elapsed_q) * STEP_W'(slew);
    end
    if (exec && uw.op == esl_pkg::OP_REMAP) begin
      map_q <= reverse ? rev_map : MAP_W'(current_throttle);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      out_timed_out <= 1'b0;
    end else if (exec && uw.last) begin
      out_valid     <= 1'b1;
      out_timed_out <= to_flag && !action_q;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign pulse_us   = last_pulse;
  assign in_startup = last_startup;
  assign timed_out  = out_timed_out;

  // An accepted transfer always starts the sequencer.
  a_accept_runs : assert property (@(posedge clk) disable iff (rst)
    accept |=> running)
    else $error("sequencer did not start after an input transfer");

  // Finishing the program always presents a result.
  a_last_emits : assert property (@(posedge clk) disable iff (rst)
    exec && uw.last |=> out_valid && !running)
    else $error("last microcode step did not load the output register");

  // The result flags agree with what the sequencer did.
  a_timeout_tick : assert property (@(posedge clk) disable iff (rst)
    exec && uw.last && uw.op == esl_pkg::OP_REQUEST |=> !timed_out)
    else $error("request result reports a command timeout");

  // Hold results carry the minimum pulse.
  a_hold_pulse : assert property (@(posedge clk) disable iff (rst)
    exec && uw.op == esl_pkg::OP_HOLD |=> in_startup && pulse_us == $past(pulse_min))
    else $error("start-up hold result is not the minimum pulse");

endmodule
